// File: rtl/core/eiv3_pkg.sv
// Shared types, widths and helper functions for the 3x3 inverse-iteration
// eigenvector unit. Depends on nothing; the core module imports it.
`default_nettype none

package eiv3_pkg;

    // Widths of the datapath.
    localparam int WORD_W     = 64;                  // input entries
    localparam int OUT_BITS   = 12;                  // result magnitude bits
    localparam int RES_W      = OUT_BITS + 1;        // signed result width
    localparam int ENT_W      = 26;                  // scaled entry, |a| <= 2^24
    localparam int DIF_W      = ENT_W + 1;           // difference of two entries
    localparam int PROD_W     = ENT_W + DIF_W;       // full product width
    localparam int VEC_W      = 52;                  // adjugate row sum, |v| < 2^51
    localparam int ORM_W      = VEC_W - OUT_BITS;    // magnitude above the kept bits
    localparam int SH_W       = 6;                   // shift amounts up to 40
    localparam int NUM_ENT    = 9;
    localparam int NUM_COMP   = 3;
    localparam int NUM_STAGES = 9;

    typedef logic signed [WORD_W-1:0] word_t;
    typedef logic signed [ENT_W-1:0]  ent_t;
    typedef logic signed [DIF_W-1:0]  dif_t;
    typedef logic signed [PROD_W-1:0] prod_t;
    typedef logic signed [VEC_W-1:0]  vec_t;
    typedef logic signed [RES_W-1:0]  res_t;
    typedef logic [SH_W-1:0]          shamt_t;

    // Magnitude classes of the largest matrix entry.
    typedef struct packed {
        logic gt24;   // above 2^24
        logic gt32;   // above 2^32
        logic gt40;   // above 2^40
        logic ge48;   // at least 2^48
        logic ge56;   // at least 2^56
    } scale_flags_t;

    localparam logic [WORD_W-1:0] LIM_24 = 64'd16777216;
    localparam logic [WORD_W-1:0] LIM_32 = 64'd4294967296;
    localparam logic [WORD_W-1:0] LIM_40 = 64'd1099511627776;
    localparam logic [WORD_W-1:0] LIM_48 = 64'd281474976710656;
    localparam logic [WORD_W-1:0] LIM_56 = 64'd72057594037927936;

    localparam shamt_t SH_NONE = 6'd0;
    localparam shamt_t SH_8    = 6'd8;
    localparam shamt_t SH_16   = 6'd16;
    localparam shamt_t SH_24   = 6'd24;
    localparam shamt_t SH_32   = 6'd32;
    localparam shamt_t SH_40   = 6'd40;

    // Full 64-bit magnitude; the most negative value maps to 2^63.
    function automatic logic [WORD_W-1:0] word_mag(input word_t x);
        logic [WORD_W-1:0] u;
        u = x;
        return u[WORD_W-1] ? (~u + WORD_W'(1)) : u;
    endfunction

    // Magnitude classes of one entry.
    function automatic scale_flags_t word_flags(input word_t x);
        logic [WORD_W-1:0] m;
        scale_flags_t f;
        m = word_mag(x);
        f.gt24 = (m > LIM_24);
        f.gt32 = (m > LIM_32);
        f.gt40 = (m > LIM_40);
        f.ge48 = (m >= LIM_48);
        f.ge56 = (m >= LIM_56);
        return f;
    endfunction

    // Matrix shift chosen from the classes of the largest entry.
    function automatic shamt_t flags_shift(input scale_flags_t f);
        shamt_t s;
        if (f.ge56)
            s = SH_40;
        else if (f.ge48)
            s = SH_32;
        else if (f.gt40)
            s = SH_24;
        else if (f.gt32)
            s = SH_16;
        else if (f.gt24)
            s = SH_8;
        else
            s = SH_NONE;
        return s;
    endfunction

    // Magnitude of a row sum; the sum never reaches -2^51.
    function automatic logic [VEC_W-1:0] vec_mag(input vec_t x);
        logic [VEC_W-1:0] u;
        u = x;
        return u[VEC_W-1] ? (~u + VEC_W'(1)) : u;
    endfunction

    // Number of bits needed to hold the value (zero for zero).
    function automatic shamt_t bit_len(input logic [ORM_W-1:0] x);
        shamt_t len;
        len = SH_NONE;
        for (int i = 0; i < ORM_W; i++)
        begin
            if (x[i])
                len = SH_W'(i + 1);
        end
        return len;
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/eigenvector_inverse_iteration_3x3_unit.sv
// Eigenvector of a 3x3 matrix by one integer inverse-iteration step.
// Imports eiv3_pkg for types, widths and the scaling helpers.
// Throughput: one item per cycle through a nine-stage pipeline while results are not
// stalled; a stalled result holds its stage and empty stages still fill behind it.
// Reset: rst_n clears only the stage valid bits; data registers are not reset.
`default_nettype none

module eigenvector_inverse_iteration_3x3_unit (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           item_valid,
    output logic                item_stall,
    input  wire eiv3_pkg::word_t a00,
    input  wire eiv3_pkg::word_t a01,
    input  wire eiv3_pkg::word_t a02,
    input  wire eiv3_pkg::word_t a10,
    input  wire eiv3_pkg::word_t a11,
    input  wire eiv3_pkg::word_t a12,
    input  wire eiv3_pkg::word_t a20,
    input  wire eiv3_pkg::word_t a21,
    input  wire eiv3_pkg::word_t a22,
    input  wire eiv3_pkg::word_t eigen_value,
    output logic                result_valid,
    input  wire logic           result_stall,
    output eiv3_pkg::res_t      vec_x,
    output eiv3_pkg::res_t      vec_y,
    output eiv3_pkg::res_t      vec_z
);

    import eiv3_pkg::*;

    logic [NUM_STAGES-1:0] vld_reg;
    logic [NUM_STAGES:0]   adv;

    word_t        in_reg   [NUM_ENT];
    word_t        eig_reg;
    word_t        raw1_reg [NUM_ENT];
    word_t        raw1_next[NUM_ENT];
    word_t        raw2_reg [NUM_ENT];
    scale_flags_t flg2_reg;
    scale_flags_t flg2_next;
    ent_t         ent3_reg [NUM_ENT];
    ent_t         ent3_next[NUM_ENT];
    ent_t         mul4_reg [NUM_ENT];
    ent_t         mul4_next[NUM_ENT];
    dif_t         dif4_reg [NUM_ENT];
    dif_t         dif4_next[NUM_ENT];
    vec_t         prod5_reg [NUM_ENT];
    vec_t         prod5_next[NUM_ENT];
    vec_t         v6_reg  [NUM_COMP];
    vec_t         v6_next [NUM_COMP];
    vec_t         v7_reg  [NUM_COMP];
    logic [ORM_W-1:0] orm7_reg;
    logic [ORM_W-1:0] orm7_next;
    res_t         res_reg [NUM_COMP];
    res_t         res_next[NUM_COMP];
    shamt_t       vec_sh;

    // Stage advance: a stage moves when it is empty or the next one moves.
    always_comb
    begin
        adv[NUM_STAGES] = !result_stall;
        for (int k = NUM_STAGES - 1; k >= 0; k--)
        begin
            adv[k] = !vld_reg[k] || adv[k + 1];
        end
    end

    assign item_stall   = !adv[0];
    assign result_valid = vld_reg[NUM_STAGES-1];

    // Stage valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (adv[0])
                vld_reg[0] <= item_valid;
            for (int k = 1; k < NUM_STAGES; k++)
            begin
                if (adv[k])
                    vld_reg[k] <= vld_reg[k - 1];
            end
        end
    end

    // Stage 1: subtract the eigenvalue estimate from the diagonal.
    always_comb
    begin
        for (int i = 0; i < NUM_ENT; i++)
        begin
            if (i == 0 || i == 4 || i == 8)
                raw1_next[i] = in_reg[i] - eig_reg;
            else
                raw1_next[i] = in_reg[i];
        end
    end

    // Stage 2: magnitude classes of all entries, merged into one set.
    always_comb
    begin
        flg2_next = '0;
        for (int i = 0; i < NUM_ENT; i++)
        begin
            flg2_next = flg2_next | word_flags(raw1_reg[i]);
        end
    end

    // Stage 3: arithmetic right shift of every entry by the matrix scale.
    always_comb
    begin
        for (int i = 0; i < NUM_ENT; i++)
        begin
            ent3_next[i] = ENT_W'(raw2_reg[i] >>> flags_shift(flg2_reg));
        end
    end

    // Stage 4: factors and entry differences of the adjugate row sums.
    // Each sum is regrouped as three products of an entry and a difference.
    always_comb
    begin
        // First component: a8(a4-a1) + a5(a1-a7) + a2(a7-a4).
        mul4_next[0] = ent3_reg[8];
        dif4_next[0] = DIF_W'(ent3_reg[4]) - DIF_W'(ent3_reg[1]);
        mul4_next[1] = ent3_reg[5];
        dif4_next[1] = DIF_W'(ent3_reg[1]) - DIF_W'(ent3_reg[7]);
        mul4_next[2] = ent3_reg[2];
        dif4_next[2] = DIF_W'(ent3_reg[7]) - DIF_W'(ent3_reg[4]);
        // Second component: a8(a0-a3) + a5(a6-a0) + a2(a3-a6).
        mul4_next[3] = ent3_reg[8];
        dif4_next[3] = DIF_W'(ent3_reg[0]) - DIF_W'(ent3_reg[3]);
        mul4_next[4] = ent3_reg[5];
        dif4_next[4] = DIF_W'(ent3_reg[6]) - DIF_W'(ent3_reg[0]);
        mul4_next[5] = ent3_reg[2];
        dif4_next[5] = DIF_W'(ent3_reg[3]) - DIF_W'(ent3_reg[6]);
        // Third component: a7(a3-a0) + a4(a0-a6) + a1(a6-a3).
        mul4_next[6] = ent3_reg[7];
        dif4_next[6] = DIF_W'(ent3_reg[3]) - DIF_W'(ent3_reg[0]);
        mul4_next[7] = ent3_reg[4];
        dif4_next[7] = DIF_W'(ent3_reg[0]) - DIF_W'(ent3_reg[6]);
        mul4_next[8] = ent3_reg[1];
        dif4_next[8] = DIF_W'(ent3_reg[6]) - DIF_W'(ent3_reg[3]);
    end

    // Stage 5: nine independent 26 x 27 signed products.
    always_comb
    begin
        prod_t p;
        for (int j = 0; j < NUM_ENT; j++)
        begin
            p = PROD_W'(mul4_reg[j]) * PROD_W'(dif4_reg[j]);
            prod5_next[j] = VEC_W'(p);
        end
    end

    // Stage 6: three products summed per component.
    always_comb
    begin
        for (int c = 0; c < NUM_COMP; c++)
        begin
            v6_next[c] = prod5_reg[3*c] + prod5_reg[3*c + 1] + prod5_reg[3*c + 2];
        end
    end

    // Stage 7: the bit length of the largest magnitude equals that of the
    // OR of all magnitudes, so the maximum search becomes an OR.
    always_comb
    begin
        logic [VEC_W-1:0] m;
        orm7_next = '0;
        for (int c = 0; c < NUM_COMP; c++)
        begin
            m = vec_mag(v6_reg[c]);
            orm7_next = orm7_next | m[VEC_W-1:OUT_BITS];
        end
    end

    // Stage 8: down-shift every component into the result range.
    assign vec_sh = bit_len(orm7_reg);

    always_comb
    begin
        for (int c = 0; c < NUM_COMP; c++)
        begin
            res_next[c] = RES_W'(v7_reg[c] >>> vec_sh);
        end
    end

    // Data registers of all stages.
    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            in_reg[0] <= a00;
            in_reg[1] <= a01;
            in_reg[2] <= a02;
            in_reg[3] <= a10;
            in_reg[4] <= a11;
            in_reg[5] <= a12;
            in_reg[6] <= a20;
            in_reg[7] <= a21;
            in_reg[8] <= a22;
            eig_reg   <= eigen_value;
        end
        if (adv[1])
            raw1_reg <= raw1_next;
        if (adv[2])
        begin
            raw2_reg <= raw1_reg;
            flg2_reg <= flg2_next;
        end
        if (adv[3])
            ent3_reg <= ent3_next;
        if (adv[4])
        begin
            mul4_reg <= mul4_next;
            dif4_reg <= dif4_next;
        end
        if (adv[5])
            prod5_reg <= prod5_next;
        if (adv[6])
            v6_reg <= v6_next;
        if (adv[7])
        begin
            v7_reg   <= v6_reg;
            orm7_reg <= orm7_next;
        end
        if (adv[8])
            res_reg <= res_next;
    end

    assign vec_x = res_reg[0];
    assign vec_y = res_reg[1];
    assign vec_z = res_reg[2];

endmodule

`default_nettype wire
